// File: hdl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; every macro samples on the rising edge and is off in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/lgbp_pkg.sv
// shared constants of the largest-gap block: beat layout and operation codes
// no dependencies
package lgbp_pkg;

  // fixed field widths of one input beat
  localparam int POS_W  = 10;
  localparam int SIZE_W = 11;

  // stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  // operation carried in tuser
  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

// File: hdl/lgbp_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
module lgbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/lgbp_join.sv
// shared segment merge unit: combines a left and a right tree segment
// no dependencies; used for tree updates, prefix gathering and the trailing gap
module lgbp_join #(
  parameter int VW = 10
) (
  input  logic          a_has,
  input  logic [VW-1:0] a_gap,
  input  logic [VW-1:0] a_first,
  input  logic [VW-1:0] a_last,
  input  logic          b_has,
  input  logic [VW-1:0] b_gap,
  input  logic [VW-1:0] b_first,
  input  logic [VW-1:0] b_last,
  output logic          r_has,
  output logic [VW-1:0] r_gap,
  output logic [VW-1:0] r_first,
  output logic [VW-1:0] r_last
);

  logic [VW-1:0] span;
  logic [VW-1:0] inner_max;
  logic          span_ok;

  // span across the seam between the two segments
  assign span      = b_first - a_last;
  assign span_ok   = a_has && b_has && (b_first >= a_last);
  assign inner_max = (a_gap > b_gap) ? a_gap : b_gap;

  // merged segment
  assign r_has   = a_has || b_has;
  assign r_first = a_has ? a_first : b_first;
  assign r_last  = b_has ? b_last : a_last;
  assign r_gap   = (span_ok && (span > inner_max)) ? span : inner_max;

endmodule

// File: hdl/largest_gap_before_position.sv
// placement: accepted in idle, leaf write, then sibling read and merge per level
// query: accepted in idle, walk from root to leaf, trailing-gap merge, result
// cost is set by the tree walk: one node read per level in one ram
// items do not overlap: a new beat is taken only when the block is back in idle
// after reset all 2**(log2(N)+1) tree ram words are swept (2048 at 1024),
// in_tready stays low until the sweep is done
module largest_gap_before_position #(
  parameter int POSITION_COUNT = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lgbp_pkg::IN_TDATA_W-1:0]    in_tdata,   // position[9:0], block_size[20:10]
  input  logic                               in_tuser,   // operation[0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lgbp_pkg::OUT_TDATA_W-1:0]   out_tdata   // fits[0]
);

  import lgbp_pkg::*;

  localparam int PW    = (POSITION_COUNT > 1) ? $clog2(POSITION_COUNT) : 1;
  localparam int AW    = PW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam int VW    = (PW > POS_W) ? PW : POS_W;
  localparam int SW    = VW + 1;
  localparam int MW    = 3 * PW + 1;
  localparam logic [VW-1:0] TOP_POS = VW'(POSITION_COUNT - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_P_LEAF, S_P_READ, S_P_JOIN,
    S_Q_READ, S_Q_JOIN, S_Q_TAIL, S_Q_OUT
  } state_t;

  state_t            state_r;
  logic [AW-1:0]     clr_addr_r;
  logic [AW-1:0]     node_r;
  logic [PW-1:0]     rbits_r;
  logic              leaf_r;
  logic [POS_W-1:0]  pos_r;
  logic [SIZE_W-1:0] size_r;
  logic              cur_has_r;
  logic [VW-1:0]     cur_gap_r;
  logic [VW-1:0]     cur_first_r;
  logic [VW-1:0]     cur_last_r;
  logic              out_tvalid_r;
  logic              out_fits_r;

  // input beat fields
  logic [POS_W-1:0]  in_pos;
  logic [SIZE_W-1:0] in_size;
  logic [VW-1:0]     in_pos_ext;
  logic [PW-1:0]     in_right;
  logic              in_place_ok;

  assign in_pos      = in_tdata[POS_W-1:0];
  assign in_size     = in_tdata[POS_W+SIZE_W-1:POS_W];
  assign in_pos_ext  = VW'(in_pos);
  assign in_right    = (in_pos_ext < TOP_POS) ? in_pos_ext[PW-1:0] : TOP_POS[PW-1:0];
  assign in_place_ok = (SW'(in_pos) < SW'(POSITION_COUNT));

  logic [VW-1:0] pos_ext;
  logic [AW-1:0] leaf_idx;
  assign pos_ext  = VW'(pos_r);
  assign leaf_idx = {1'b1, pos_ext[PW-1:0]};

  // tree ram, word = {has, gap, last, first}
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [MW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [MW-1:0] ram_rdata;

  lgbp_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic          m_has;
  logic [VW-1:0] m_gap;
  logic [VW-1:0] m_first;
  logic [VW-1:0] m_last;
  assign m_first = VW'(ram_rdata[PW-1:0]);
  assign m_last  = VW'(ram_rdata[2*PW-1:PW]);
  assign m_gap   = VW'(ram_rdata[3*PW-1:2*PW]);
  assign m_has   = ram_rdata[3*PW];

  // shared merge unit and its operand selection
  logic          a_has, b_has, r_has;
  logic [VW-1:0] a_gap, a_first, a_last;
  logic [VW-1:0] b_gap, b_first, b_last;
  logic [VW-1:0] r_gap, r_first, r_last;
  logic          mem_left;

  assign mem_left = (state_r == S_P_JOIN) && node_r[0];

  always_comb begin
    if (mem_left) begin
      a_has = m_has;     a_gap = m_gap;     a_first = m_first;     a_last = m_last;
      b_has = cur_has_r; b_gap = cur_gap_r; b_first = cur_first_r; b_last = cur_last_r;
    end else if (state_r == S_Q_TAIL) begin
      a_has = cur_has_r; a_gap = cur_gap_r; a_first = cur_first_r; a_last = cur_last_r;
      b_has = 1'b1;      b_gap = '0;        b_first = pos_ext;     b_last = pos_ext;
    end else begin
      a_has = cur_has_r; a_gap = cur_gap_r; a_first = cur_first_r; a_last = cur_last_r;
      b_has = m_has;     b_gap = m_gap;     b_first = m_first;     b_last = m_last;
    end
  end

  lgbp_join #(
    .VW (VW)
  ) u_join (
    .a_has   (a_has),
    .a_gap   (a_gap),
    .a_first (a_first),
    .a_last  (a_last),
    .b_has   (b_has),
    .b_gap   (b_gap),
    .b_first (b_first),
    .b_last  (b_last),
    .r_has   (r_has),
    .r_gap   (r_gap),
    .r_first (r_first),
    .r_last  (r_last)
  );

  // nodes on the leftmost path start out holding the obstacle at zero
  logic clr_on_path;
  assign clr_on_path = (clr_addr_r != '0) && ((clr_addr_r & (clr_addr_r - AW'(1))) == '0);

  // ram port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node_r >> 1;
    ram_wdata = {r_has, r_gap[PW-1:0], r_last[PW-1:0], r_first[PW-1:0]};
    ram_raddr = node_r;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = {clr_on_path, {(3*PW){1'b0}}};
      end
      S_P_LEAF: begin
        ram_we    = 1'b1;
        ram_waddr = leaf_idx;
        ram_wdata = {1'b1, {PW{1'b0}}, pos_ext[PW-1:0], pos_ext[PW-1:0]};
      end
      S_P_READ: begin
        ram_raddr = node_r ^ AW'(1);
      end
      S_P_JOIN: begin
        ram_we = 1'b1;
      end
      S_Q_READ: begin
        ram_raddr = node_r[AW-1] ? node_r : {node_r[AW-2:0], 1'b0};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // sequencer with registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // the output state reloads a taken result beat by itself
      if (out_tvalid_r && out_tready && (state_r != S_Q_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (&clr_addr_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            pos_r  <= in_pos;
            size_r <= in_size;
            if (in_tuser == OP_QUERY) begin
              node_r      <= AW'(1);
              rbits_r     <= in_right;
              leaf_r      <= 1'b0;
              cur_has_r   <= 1'b0;
              cur_gap_r   <= '0;
              cur_first_r <= '0;
              cur_last_r  <= '0;
              state_r     <= S_Q_READ;
            end else if (in_place_ok) begin
              state_r <= S_P_LEAF;
            end
          end
        end
        S_P_LEAF: begin
          cur_has_r   <= 1'b1;
          cur_gap_r   <= '0;
          cur_first_r <= pos_ext;
          cur_last_r  <= pos_ext;
          node_r      <= leaf_idx;
          state_r     <= S_P_READ;
        end
        S_P_READ: begin
          state_r <= S_P_JOIN;
        end
        S_P_JOIN: begin
          cur_has_r   <= r_has;
          cur_gap_r   <= r_gap;
          cur_first_r <= r_first;
          cur_last_r  <= r_last;
          node_r      <= node_r >> 1;
          if ((node_r >> 1) == AW'(1)) begin
            state_r <= S_IDLE;
          end else begin
            state_r <= S_P_READ;
          end
        end
        S_Q_READ: begin
          // take the whole left child when the range runs into the right one
          if (node_r[AW-1]) begin
            leaf_r  <= 1'b1;
            state_r <= S_Q_JOIN;
          end else if (rbits_r[PW-1]) begin
            node_r  <= {node_r[AW-2:0], 1'b1};
            rbits_r <= rbits_r << 1;
            state_r <= S_Q_JOIN;
          end else begin
            node_r  <= {node_r[AW-2:0], 1'b0};
            rbits_r <= rbits_r << 1;
          end
        end
        S_Q_JOIN: begin
          cur_has_r   <= r_has;
          cur_gap_r   <= r_gap;
          cur_first_r <= r_first;
          cur_last_r  <= r_last;
          state_r     <= leaf_r ? S_Q_TAIL : S_Q_READ;
        end
        S_Q_TAIL: begin
          // trailing gap up to the queried position
          cur_gap_r <= r_gap;
          state_r   <= S_Q_OUT;
        end
        S_Q_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_fits_r   <= ({1'b0, cur_gap_r} >= SW'(size_r));
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_fits_r};

endmodule

// File: hdl/lgbp_checker.sv
// port-level checker for the largest-gap block, bound to the top level
// depends on lgbp_pkg and assert_macros.svh
`include "assert_macros.svh"

module lgbp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lgbp_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import lgbp_pkg::*;

  // handshake shorthands
  logic in_beat;
  logic out_stall;
  assign in_beat   = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;

  // a stalled result beat holds
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata))

  // a query keeps the block busy in the next cycle
  `ASSERT_NXT(a_query_busy, clk, rst_n, in_beat && (in_tuser == OP_QUERY), !in_tready)

  // a placement never raises a result right away
  `ASSERT_NXT(a_place_quiet, clk, rst_n, in_beat && (in_tuser == OP_PLACE) && !out_tvalid, !out_tvalid)

  // a result appears only at the end of a busy stretch
  `ASSERT_IMP(a_out_from_work, clk, rst_n, $rose(out_tvalid), !$past(in_tready))

endmodule

bind largest_gap_before_position lgbp_checker u_lgbp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: dv/tb_largest_gap_before_position.sv
// self-checking bench for largest_gap_before_position: obstacle placements and fit queries
// depends on lgbp_pkg and the block rtl; a small scoreboard class keeps the obstacle line
// and predicts each fits answer, plain tasks drive the stream ports with random idling
module tb_largest_gap_before_position;
  timeunit 1ns;
  timeprecision 1ps;

  import lgbp_pkg::*;

  localparam int LINE_LEN       = 1024;
  localparam int IDLE_LIMIT     = 8000;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int QUIET_ITEMS    = 150;
  localparam int DRAIN_CYCLES   = 64;

  // obstacle line model and queue of expected fits answers
  class gap_scoreboard;
    bit [LINE_LEN-1:0] obstacle_map;
    bit                expected_fits[$];
    int unsigned       fail_count;
    int unsigned       place_count;
    int unsigned       query_count;
    int unsigned       fits_seen;
    int unsigned       misses_seen;

    function new();
      obstacle_map    = '0;
      obstacle_map[0] = 1'b1;
    endfunction

    // largest free stretch in [0, position], trailing stretch included
    function int unsigned widest_gap(logic [POS_W-1:0] position);
      int unsigned last_seen;
      int unsigned best;
      last_seen = 0;
      best      = 0;
      for (int p = 1; p <= int'(position); p++) begin
        if (obstacle_map[p]) begin
          if (p - last_seen > best) best = p - last_seen;
          last_seen = p;
        end
      end
      if (position - last_seen > best) best = position - last_seen;
      return best;
    endfunction

    function void note_item(logic op, logic [POS_W-1:0] position, logic [SIZE_W-1:0] block_size);
      if (op == OP_PLACE) begin
        obstacle_map[position] = 1'b1;
        place_count++;
      end else begin
        expected_fits = {expected_fits, bit'(widest_gap(position) >= block_size)};
        query_count++;
      end
    endfunction

    function int pending();
      return expected_fits.size();
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      fail_count++;
    endtask

    task check_fits(logic got);
      bit want;
      if (expected_fits.size() == 0) begin
        report_mismatch($sformatf("result beat fits=%b with no query pending", got));
      end else begin
        want = expected_fits.pop_front();
        if (got !== want)
          report_mismatch($sformatf("fits got %b, expected %b", got, want));
        if (want) fits_seen++;
        else misses_seen++;
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // position[9:0], block_size[20:10]
  logic                   in_tuser;   // operation[0]
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // fits[0]

  gap_scoreboard sb = new();
  bit            quiet_tail = 1'b0;
  int unsigned   idle_cycles = 0;

  largest_gap_before_position dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one input beat, with an optional idle burst ahead of it
  task automatic send_item(logic op, logic [POS_W-1:0] position, logic [SIZE_W-1:0] block_size);
    int gap_len;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap_len = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap_len) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'({block_size, position});
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, position, block_size);
  endtask

  // mostly queries; sizes often sit right at the current widest gap
  task automatic send_random(int count);
    logic                op;
    logic [POS_W-1:0]    position;
    logic [SIZE_W-1:0]   block_size;
    int unsigned         widest;
    int unsigned         pick;
    for (int i = 0; i < count; i++) begin
      if (i == count - QUIET_ITEMS) quiet_tail = 1'b1;
      op = ($urandom_range(0, 99) < 18) ? OP_PLACE : OP_QUERY;
      pick = $urandom_range(0, 19);
      if (pick == 0) position = '0;
      else if (pick == 1) position = '1;
      else position = POS_W'($urandom_range(0, LINE_LEN - 1));
      pick = $urandom_range(0, 9);
      if (op == OP_QUERY && pick < 5) begin
        widest = sb.widest_gap(position);
        if (widest == 0) block_size = SIZE_W'($urandom_range(0, 1));
        else block_size = SIZE_W'(widest + $urandom_range(0, 2) - 1);
      end else if (pick == 5) begin
        block_size = SIZE_W'($urandom_range(0, 2047));
      end else begin
        block_size = SIZE_W'($urandom_range(0, 64));
      end
      send_item(op, position, block_size);
    end
  endtask

  // result side backpressure in random bursts
  initial begin
    int run_len;
    out_tready <= 1'b0;
    forever begin
      if (quiet_tail || $urandom_range(0, 1) == 1) begin
        out_tready <= 1'b1;
        run_len = $urandom_range(1, 16);
      end else begin
        out_tready <= 1'b0;
        run_len = $urandom_range(1, 6);
      end
      repeat (run_len) @(posedge clk);
    end
  end

  // check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_fits(out_tdata[0]);
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("largest_gap_before_position verification failed");
      $finish;
    end
  end

  // reset, directed items, random items, drain
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_PLACE;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // only the reset obstacle at zero: zero size, empty line, full line
    send_item(OP_QUERY, 10'd0, 11'd0);
    send_item(OP_QUERY, 10'd0, 11'd1);
    send_item(OP_QUERY, 10'd0, 11'd2047);
    send_item(OP_QUERY, 10'd1023, 11'd1023);
    send_item(OP_QUERY, 10'd1023, 11'd1024);
    // obstacle at the far end, queried at and just before it
    send_item(OP_PLACE, 10'd1023, 11'd2047);
    send_item(OP_QUERY, 10'd1023, 11'd1023);
    send_item(OP_QUERY, 10'd1022, 11'd1022);
    send_item(OP_QUERY, 10'd1023, 11'd1024);
    // middle obstacle, placed twice, and a repeat of the one at zero
    send_item(OP_PLACE, 10'd512, 11'd0);
    send_item(OP_PLACE, 10'd512, 11'd1365);
    send_item(OP_PLACE, 10'd0, 11'd682);
    send_item(OP_QUERY, 10'd1023, 11'd512);
    send_item(OP_QUERY, 10'd1023, 11'd513);
    send_item(OP_QUERY, 10'd512, 11'd512);
    send_item(OP_QUERY, 10'd511, 11'd511);
    send_item(OP_QUERY, 10'd511, 11'd512);
    // alternating bit patterns on position and size
    send_item(OP_PLACE, 10'd341, 11'd1365);
    send_item(OP_PLACE, 10'd682, 11'd682);
    send_item(OP_QUERY, 10'd682, 11'd1365);
    send_item(OP_QUERY, 10'd682, 11'd171);
    send_item(OP_QUERY, 10'd341, 11'd341);
    send_item(OP_QUERY, 10'd700, 11'd18);

    send_random(RANDOM_ITEMS);
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d placements and %0d fit queries (%0d fit, %0d did not)",
             sb.place_count, sb.query_count, sb.fits_seen, sb.misses_seen);
    $display("mismatches: %0d", sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("largest_gap_before_position verification clean");
    end else begin
      $display("largest_gap_before_position verification failed");
    end
    $finish;
  end

endmodule
